// ===== design/i2a_pkg.sv =====
// Shared types and codes for the integer-to-ASCII formatter.
// Used by i2a_ctrl, i2a_dp and integer_to_ascii_formatter_top; no dependencies.
package i2a_pkg;

	localparam int VAL_W    = 32;
	localparam int NDIG     = 10;          // BCD digits needed for a 32-bit magnitude
	localparam int BCD_W    = NDIG * 4;
	localparam int STEP_W   = 5;           // counts the VAL_W shift steps
	localparam int PTR_W    = 4;           // indexes the NDIG digits
	localparam int CNT_W    = 4;

	localparam logic [1:0] FUNC_SDEC = 2'd0;
	localparam logic [1:0] FUNC_UDEC = 2'd1;
	localparam logic [1:0] FUNC_HEXL = 2'd2;
	localparam logic [1:0] FUNC_HEXU = 2'd3;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ALO   = 8'h57;   // 'a' - 10
	localparam logic [7:0] CHAR_AUP   = 8'h37;   // 'A' - 10

	typedef struct packed {
		logic [1:0]       func;
		logic [VAL_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [7:0]       char_code;
		logic             last_char;
		logic [CNT_W-1:0] char_count;
	} ascii_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic size;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic item_hex;
		logic conv_done;
		logic emit_last;
		logic out_free;
	} sts_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_SIZE = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

endpackage

// ===== design/i2a_ctrl.sv =====
// Sequencer for the integer-to-ASCII formatter: load, convert, size, emit.
// Depends on i2a_pkg; drives the command struct of i2a_dp.
module i2a_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  i2a_pkg::sts_t sts,
	output i2a_pkg::cmd_t cmd,
	output logic          idle
);
	import i2a_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.item_hex ? S_SIZE : S_CONV;
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_done) begin
					state_d = S_SIZE;
				end
			end
			S_SIZE: begin
				cmd.size = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);

endmodule

// ===== design/i2a_dp.sv =====
// Datapath: magnitude and BCD shift registers (shift-and-add-3), digit
// pointer, sign flag and the output register. Depends on i2a_pkg.
module i2a_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  i2a_pkg::item_t  item,
	input  i2a_pkg::cmd_t   cmd,
	output i2a_pkg::sts_t   sts,
	output logic            ascii_valid,
	input  logic            ascii_stall,
	output i2a_pkg::ascii_t ascii
);
	import i2a_pkg::*;

	logic [VAL_W-1:0]  mag_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [STEP_W-1:0] step_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sign_q;
	logic              hex_q;
	logic              upper_q;
	logic              valid_q;
	ascii_t            out_q;

	logic              item_hex;
	logic              item_neg;
	logic [VAL_W-1:0]  item_mag;
	logic [BCD_W-1:0]  bcd_adj;
	logic [PTR_W-1:0]  top_dig;
	logic [3:0]        cur_dig;
	logic [7:0]        cur_char;
	logic              out_free;

	assign item_hex = (item.func == FUNC_HEXL) || (item.func == FUNC_HEXU);
	assign item_neg = (item.func == FUNC_SDEC) && item.value[VAL_W-1];
	assign item_mag = item_neg ? (VAL_W'(0) - item.value) : item.value;

	// add 3 to every digit of 5 or more ahead of the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// index of the highest nonzero digit; zero when all digits are zero
	always_comb begin
		top_dig = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				top_dig = PTR_W'(i);
			end
		end
	end

	assign cur_dig = bcd_q[ptr_q*4 +: 4];

	always_comb begin
		if (sign_q) begin
			cur_char = CHAR_MINUS;
		end else if (hex_q && cur_dig >= 4'd10) begin
			cur_char = (upper_q ? CHAR_AUP : CHAR_ALO) + {4'd0, cur_dig};
		end else begin
			cur_char = CHAR_ZERO + {4'd0, cur_dig};
		end
	end

	assign out_free = !valid_q || !ascii_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (!ascii_stall) begin
				valid_q <= 1'b0;
			end
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.conv_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sign_q  <= item_neg;
			hex_q   <= item_hex;
			upper_q <= (item.func == FUNC_HEXU);
			mag_q   <= item_mag;
			bcd_q   <= item_hex ? {{(BCD_W-VAL_W){1'b0}}, item.value} : '0;
		end
		if (cmd.conv_step) begin
			{bcd_q, mag_q} <= {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
		end
		if (cmd.size) begin
			ptr_q <= top_dig;
			cnt_q <= '0;
		end
		if (cmd.emit) begin
			out_q.char_code  <= cur_char;
			out_q.last_char  <= !sign_q && (ptr_q == '0);
			out_q.char_count <= cnt_q + CNT_W'(1);
			cnt_q            <= cnt_q + CNT_W'(1);
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				ptr_q <= ptr_q - PTR_W'(1);
			end
		end
	end

	assign sts.item_hex  = item_hex;
	assign sts.conv_done = (step_q == STEP_W'(VAL_W - 1));
	assign sts.emit_last = !sign_q && (ptr_q == '0);
	assign sts.out_free  = out_free;

	assign ascii_valid = valid_q;
	assign ascii       = out_q;

endmodule

// ===== design/integer_to_ascii_formatter_top.sv =====
// Integer-to-ASCII formatter: one 32-bit value in, its ASCII characters out,
// one character per beat, most significant digit first, no leading zeros. In
// signed mode a negative value leads with '-'. Each beat carries the character,
// a last flag and the running count. The block works on one value at a time:
// the accept cycle, then for decimal modes the shift-and-add-3 steps in the
// BCD register plus a sizing cycle (hex goes straight to sizing), then one
// character per cycle while the output is not stalled. A decimal value gives
// 1 to 11 characters, a hex value 1 to 8. The next value is taken as soon as
// the last character sits in the output register.
// Depends on i2a_pkg, i2a_ctrl and i2a_dp.
module integer_to_ascii_formatter_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  i2a_pkg::item_t  item,
	output logic            ascii_valid,
	input  logic            ascii_stall,
	output i2a_pkg::ascii_t ascii
);
	import i2a_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle;

	i2a_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.sts        (sts),
		.cmd        (cmd),
		.idle       (idle)
	);

	i2a_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.sts         (sts),
		.ascii_valid (ascii_valid),
		.ascii_stall (ascii_stall),
		.ascii       (ascii)
	);

	assign item_stall = !idle;

	// no new value may enter while a value is only partly emitted
	a_no_accept_mid_value: assert property (@(posedge clk) disable iff (!arst_n)
		ascii_valid && !ascii.last_char |-> item_stall)
		else $error("item accepted before the last character was produced");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ascii_valid |-> (ascii.char_count != 4'd0) && (ascii.char_count <= 4'd11))
		else $error("character count out of range");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		ascii_valid && (ascii.char_code == CHAR_MINUS) |-> (ascii.char_count == 4'd1))
		else $error("minus sign not in first position");

endmodule
